[sv/ots_pkg.sv]
// Shared types and codes for the one-shot timer table.
// Used by ots_cell and one_shot_timer_table_top; depends on nothing else.
package ots_pkg;

    localparam int TICK_W = 32;

    // operation codes on the input word
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // status codes on the result word
    localparam logic [2:0] STS_CREATED  = 3'd0;
    localparam logic [2:0] STS_REJECTED = 3'd1;
    localparam logic [2:0] STS_DELETED  = 3'd2;
    localparam logic [2:0] STS_NO_FIRE  = 3'd3;
    localparam logic [2:0] STS_FIRED    = 3'd4;

    // what a searching token looks for in a cell
    typedef enum logic {
        MODE_CREATE,
        MODE_FIRE
    } mode_t;

    // broadcast to every cell: deadline to store on create, current tick on fire
    typedef struct packed {
        mode_t              mode;
        logic [TICK_W-1:0]  value;
    } cmd_t;

endpackage

[sv/ots_cell.sv]
// One timer slot: active flag, deadline and a search token that moves to the next slot.
// Depends on ots_pkg.
module ots_cell
    import ots_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic tok_in,
    input  logic clear,
    input  cmd_t cmd,
    output logic tok_out,
    output logic hit
);

    logic              token_reg;
    logic              active_reg;
    logic              active_next;
    logic [TICK_W-1:0] deadline_reg;
    logic              match;

    always_comb begin
        if (cmd.mode == MODE_CREATE) begin
            match = !active_reg;
        end else begin
            match = active_reg && (cmd.value >= deadline_reg);
        end
    end

    assign hit     = token_reg && match;
    assign tok_out = token_reg && !match;

    always_comb begin
        active_next = active_reg;
        if (hit) begin
            // claim on create, free on fire
            active_next = (cmd.mode == MODE_CREATE);
        end else if (clear) begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg  <= 1'b0;
            active_reg <= 1'b0;
        end else begin
            token_reg  <= tok_in;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit && cmd.mode == MODE_CREATE) begin
            deadline_reg <= cmd.value;
        end
    end

endmodule

[sv/one_shot_timer_table_top.sv]
// Top level of the one-shot timer table: controller, tick counter and a chain of slot cells.
// Depends on ots_pkg and ots_cell.
//
// Each input word is one of tick, create or delete and gives exactly one result word.
// Create and tick launch a token at slot 0 that walks the chain one slot per cycle and
// stops at the first slot that matches (a free slot for create, an expired active slot
// for tick), and the result waits in S_HOLD once the token has matched or run off the end.
// Delete, a zero timeout and an unknown operation skip the walk and go straight to S_HOLD.
// A new word is accepted once the previous result has reached the output register, even
// while that result still waits for m_ready.
module one_shot_timer_table_top
    import ots_pkg::*;
#(
    parameter int NUM_SLOTS = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic [TICK_W-1:0] s_timeout,
    input  logic [3:0]        s_slot,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [3:0]        m_slot_index,
    output logic [TICK_W-1:0] m_tick_now
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t            state_reg,  state_next;
    logic [TICK_W-1:0] tick_reg,   tick_next;
    cmd_t              cmd_reg,    cmd_next;
    logic [IDX_W-1:0]  pos_reg,    pos_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [3:0]        res_index_reg,  res_index_next;
    logic              m_valid_reg,    m_valid_next;
    logic [2:0]        m_status_reg,   m_status_next;
    logic [3:0]        m_index_reg,    m_index_next;
    logic [TICK_W-1:0] m_tick_reg,     m_tick_next;

    logic                 accept;
    logic                 launch;
    logic                 del_en;
    logic [NUM_SLOTS:0]   tok;
    logic [NUM_SLOTS-1:0] hits;
    logic                 hit_any;
    logic [IDX_W+3:0]     pos_wide;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign hit_any = |hits;
    assign pos_wide = {4'b0000, pos_reg};
    assign del_en  = accept && (s_operation == OP_DELETE);
    assign tok[0]  = launch;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
            ots_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_in  (tok[gi]),
                .clear   (del_en && (32'(s_slot) == 32'(gi))),
                .cmd     (cmd_reg),
                .tok_out (tok[gi+1]),
                .hit     (hits[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        m_tick_next     = m_tick_reg;
        launch          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_index_next = 4'd0;
                    pos_next       = '0;
                    unique case (s_operation)
                        OP_TICK: begin
                            tick_next      = tick_reg + 1'b1;
                            cmd_next.mode  = MODE_FIRE;
                            cmd_next.value = tick_reg + 1'b1;
                            launch         = 1'b1;
                            state_next     = S_SCAN;
                        end
                        OP_CREATE: begin
                            cmd_next.mode  = MODE_CREATE;
                            cmd_next.value = tick_reg + s_timeout;
                            if (s_timeout != '0) begin
                                launch     = 1'b1;
                                state_next = S_SCAN;
                            end else begin
                                res_status_next = STS_REJECTED;
                                state_next      = S_HOLD;
                            end
                        end
                        OP_DELETE: begin
                            res_status_next = STS_DELETED;
                            state_next      = S_HOLD;
                        end
                        default: begin
                            res_status_next = STS_REJECTED;
                            state_next      = S_HOLD;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                pos_next = pos_reg + 1'b1;
                if (hit_any) begin
                    res_status_next = (cmd_reg.mode == MODE_CREATE) ? STS_CREATED : STS_FIRED;
                    res_index_next  = pos_wide[3:0];
                    state_next      = S_HOLD;
                end else if (tok[NUM_SLOTS]) begin
                    // token ran off the end: table full or nothing expired
                    res_status_next = (cmd_reg.mode == MODE_CREATE) ? STS_REJECTED : STS_NO_FIRE;
                    res_index_next  = 4'd0;
                    state_next      = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    m_tick_next   = tick_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
        m_tick_reg     <= m_tick_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_slot_index = m_index_reg;
    assign m_tick_now   = m_tick_reg;

endmodule
